// File: hw/rtl/triangle_unit_normal_top_assert.svh
// Assertion macros used by the RTL queue (tun_queue.sv).
`ifndef TRIANGLE_UNIT_NORMAL_TOP_ASSERT_SVH
`define TRIANGLE_UNIT_NORMAL_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TUN_ASSERT(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tun assertion failed");
`define TUN_ASSERT_NORST(name, prop) \
    name: assert property (@(posedge i_clk) prop) else $error("tun assertion failed");
`else
`define TUN_ASSERT(name, prop)
`define TUN_ASSERT_NORST(name, prop)
`endif
`endif

// File: hw/rtl/tun_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tun_pkg;
    localparam int CW     = 24;            // coordinate width
    localparam int DW     = CW + 1;        // edge vector component
    localparam int XW     = 2 * CW + 2;    // signed cross product component
    localparam int CMW    = 2 * CW + 1;    // cross product magnitude
    localparam int LO_W   = CMW / 2;
    localparam int HI_W   = CMW - LO_W;
    localparam int SQW    = 2 * CMW;       // squared component
    localparam int SW     = SQW + 2;       // sum of squares
    localparam int QW     = 61;            // quotient c^2 * 2^60 / S, at most 2^60
    localparam int RW     = 31;            // root, at most 2^30
    localparam int SRW    = 2 * RW;        // root remainder
    localparam int OW     = 32;
    localparam int IN_W   = ((9 * CW + 7) / 8) * 8;
    localparam int OUT_TW = 3 * OW;
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int QCW    = 3;

    typedef struct packed {
        logic [2:0][SQW-1:0] sq;
        logic [2:0]          neg;
        logic [SW-1:0]       s;
        logic                deg;
    } t_item;
endpackage
`default_nettype wire

// File: hw/rtl/tun_front.sv
`timescale 1ns / 1ps
`default_nettype none
module tun_front import tun_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [IN_W-1:0] i_data,
    input  wire logic            i_q_full,
    output logic                 o_push,
    output t_item                o_item
);
    logic [5:0] r_v;
    logic       en;

    logic signed [CW-1:0]  crd [9];
    logic signed [DW-1:0]  r_u [3];
    logic signed [DW-1:0]  r_w [3];
    logic signed [XW-1:0]  r_p [6];
    logic signed [XW-1:0]  n_c [3];
    logic signed [XW-1:0]  n_abs [3];
    logic [CMW-1:0]        r_mag [3];
    logic [2:0]            r_neg3, r_neg4, r_neg5;
    logic [2*HI_W-1:0]     r_hh [3];
    logic [HI_W+LO_W-1:0]  r_hl [3];
    logic [2*LO_W-1:0]     r_ll [3];
    logic [SQW-1:0]        r_sq [3];
    t_item                 r_item;

    assign en      = !(r_v[5] && i_q_full);
    assign o_ready = en;
    assign o_push  = r_v[5] && !i_q_full;
    assign o_item  = r_item;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            crd[k] = i_data[k*CW +: CW];
        end
        for (int i = 0; i < 3; i++) begin
            n_c[i]   = r_p[2*i] - r_p[2*i+1];
            n_abs[i] = n_c[i][XW-1] ? -n_c[i] : n_c[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_u[i] <= DW'(crd[i]) - DW'(crd[i+3]);
                r_w[i] <= DW'(crd[i]) - DW'(crd[i+6]);
            end
            r_p[0] <= r_u[1] * r_w[2];
            r_p[1] <= r_w[1] * r_u[2];
            r_p[2] <= r_w[0] * r_u[2];
            r_p[3] <= r_u[0] * r_w[2];
            r_p[4] <= r_u[0] * r_w[1];
            r_p[5] <= r_w[0] * r_u[1];
            for (int i = 0; i < 3; i++) begin
                r_neg3[i] <= n_c[i][XW-1];
                r_mag[i]  <= n_abs[i][CMW-1:0];
                // square split into partial products
                r_hh[i] <= r_mag[i][CMW-1:LO_W] * r_mag[i][CMW-1:LO_W];
                r_hl[i] <= r_mag[i][CMW-1:LO_W] * r_mag[i][LO_W-1:0];
                r_ll[i] <= r_mag[i][LO_W-1:0] * r_mag[i][LO_W-1:0];
                r_sq[i] <= (SQW'(r_hh[i]) << (2 * LO_W)) + (SQW'(r_hl[i]) << (LO_W + 1))
                           + SQW'(r_ll[i]);
                r_item.sq[i] <= r_sq[i];
            end
            r_neg4       <= r_neg3;
            r_neg5       <= r_neg4;
            r_item.neg   <= r_neg5;
            r_item.s     <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
            r_item.deg   <= (r_sq[0] == '0) && (r_sq[1] == '0) && (r_sq[2] == '0);
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/tun_queue.sv
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_unit_normal_top_assert.svh"
module tun_queue import tun_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_empty,
    output t_item      o_item
);
    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_cnt;

    assign o_full  = (r_cnt == QCW'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    `TUN_ASSERT(a_cnt_bound, r_cnt <= QCW'(QDEPTH))
    `TUN_ASSERT(a_no_pop_empty, i_pop |-> r_cnt != '0)
    `TUN_ASSERT(a_no_push_full, i_push |-> r_cnt != QCW'(QDEPTH))
    `TUN_ASSERT(a_cnt_track, i_push && !i_pop |=> r_cnt == $past(r_cnt) + 1'b1)
endmodule
`default_nettype wire

// File: hw/rtl/tun_back.sv
`timescale 1ns / 1ps
`default_nettype none
module tun_back import tun_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_empty,
    input  wire t_item             i_item,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [OUT_TW-1:0]      o_data,
    output logic                   o_deg
);
    logic en;

    // divider stages: one quotient bit each
    logic [QW-1:0]            r_dv;
    logic [2:0][SW-1:0]       r_rem  [QW];
    logic [2:0][QW-1:0]       r_quo  [QW];
    logic [SW-1:0]            r_ds   [QW];
    logic [2:0]               r_dneg [QW];
    logic                     r_ddeg [QW];
    logic [2:0][SW-1:0]       n_rem  [QW];
    logic [2:0][QW-1:0]       n_quo  [QW];

    // square root stages: one root bit each
    logic [RW-1:0]            r_sv;
    logic [2:0][SRW-1:0]      r_srem [RW];
    logic [2:0][RW-1:0]       r_root [RW];
    logic [2:0]               r_sneg [RW];
    logic                     r_sdeg [RW];
    logic [2:0][SRW-1:0]      n_srem [RW];
    logic [2:0][RW-1:0]       n_root [RW];

    logic                     r_ov;
    logic [OUT_TW-1:0]        r_od;
    logic                     r_odeg;
    logic [OUT_TW-1:0]        n_od;

    assign en      = !r_ov || i_ready;
    assign o_pop   = en && !i_empty;
    assign o_valid = r_ov;
    assign o_data  = r_od;
    assign o_deg   = r_odeg;

    always_comb begin
        logic [SW:0]  dbl;
        logic         bt;
        logic [SRW-1:0] rin, trial;
        logic [RW-1:0]  qin;
        int           b;
        for (int l = 0; l < 3; l++) begin
            // top quotient bit: c^2 never exceeds S
            bt          = SW'(i_item.sq[l]) >= i_item.s;
            n_rem[0][l] = bt ? SW'(i_item.sq[l]) - i_item.s : SW'(i_item.sq[l]);
            n_quo[0][l] = QW'(bt);
        end
        for (int k = 1; k < QW; k++) begin
            for (int l = 0; l < 3; l++) begin
                dbl         = {r_rem[k-1][l], 1'b0};
                bt          = dbl >= {1'b0, r_ds[k-1]};
                dbl         = bt ? dbl - {1'b0, r_ds[k-1]} : dbl;
                n_rem[k][l] = dbl[SW-1:0];
                n_quo[k][l] = {r_quo[k-1][l][QW-2:0], bt};
            end
        end
        for (int j = 0; j < RW; j++) begin
            b = RW - 1 - j;
            for (int l = 0; l < 3; l++) begin
                if (j == 0) begin
                    rin = SRW'(r_quo[QW-1][l]);
                    qin = '0;
                end else begin
                    rin = r_srem[j-1][l];
                    qin = r_root[j-1][l];
                end
                trial = (SRW'(qin) << (b + 1)) | (SRW'(1) << (2 * b));
                if (rin >= trial) begin
                    n_srem[j][l] = rin - trial;
                    n_root[j][l] = qin | (RW'(1) << b);
                end else begin
                    n_srem[j][l] = rin;
                    n_root[j][l] = qin;
                end
            end
        end
        for (int l = 0; l < 3; l++) begin
            if (r_sdeg[RW-1]) begin
                n_od[l*OW +: OW] = '0;
            end else if (r_sneg[RW-1][l]) begin
                n_od[l*OW +: OW] = -OW'(r_root[RW-1][l]);
            end else begin
                n_od[l*OW +: OW] = OW'(r_root[RW-1][l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
            r_sv <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_dv <= {r_dv[QW-2:0], o_pop};
            r_sv <= {r_sv[RW-2:0], r_dv[QW-1]};
            r_ov <= r_sv[RW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
                if (k == 0) begin
                    r_ds[k]   <= i_item.s;
                    r_dneg[k] <= i_item.neg;
                    r_ddeg[k] <= i_item.deg;
                end else begin
                    r_ds[k]   <= r_ds[k-1];
                    r_dneg[k] <= r_dneg[k-1];
                    r_ddeg[k] <= r_ddeg[k-1];
                end
            end
            for (int j = 0; j < RW; j++) begin
                r_srem[j] <= n_srem[j];
                r_root[j] <= n_root[j];
                if (j == 0) begin
                    r_sneg[j] <= r_dneg[QW-1];
                    r_sdeg[j] <= r_ddeg[QW-1];
                end else begin
                    r_sneg[j] <= r_sneg[j-1];
                    r_sdeg[j] <= r_sdeg[j-1];
                end
            end
            r_od   <= n_od;
            r_odeg <= r_sdeg[RW-1];
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/triangle_unit_normal_top.sv
// Unit face normal of a triangle, Q8.16 vertices in, Q1.30 components out.
// Data path: 6 cross product / square stages, queue, 61 divider stages,
// 31 root stages, output register.
// Throughput: one triangle per cycle while the output is ready; a 4-entry queue splits front and back.
// Reset: synchronous active-low i_rst_n clears all valid bits and the queue.
`timescale 1ns / 1ps
`default_nettype none
module triangle_unit_normal_top import tun_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // ax, ay, az, bx, by_coord, bz, cx, cy, cz
    input  wire logic [IN_W-1:0]   i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    // nx, ny, nz
    output logic [OUT_TW-1:0]      o_m_axis_tdata,
    // degenerate
    output logic                   o_m_axis_tuser
);
    logic  push, full, empty, pop;
    t_item f_item, q_item;

    tun_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_data   (i_s_axis_tdata),
        .i_q_full (full),
        .o_push   (push),
        .o_item   (f_item)
    );

    tun_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (q_item)
    );

    tun_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_item  (q_item),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_deg   (o_m_axis_tuser)
    );
endmodule
`default_nettype wire
